>>> hdl/lcs_pkg.sv
package lcs_pkg;

  // Default capacity of each string, in symbols.
  localparam int unsigned MAX_LEN_DEF = 32;

  // Width of one symbol and of the result value field.
  localparam int unsigned SYM_W = 8;

  // Result kinds.
  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  // Input actions. The fourth code is ignored by the block.
  typedef enum logic [1:0] {
    ACT_APPEND_FIRST  = 2'd0,
    ACT_APPEND_SECOND = 2'd1,
    ACT_COMPUTE       = 2'd2
  } action_e;

  // Direction codes stored per table cell.
  typedef enum logic [1:0] {
    DIR_DIAG = 2'd0,
    DIR_UP   = 2'd1,
    DIR_LEFT = 2'd2
  } dir_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_FLUSH,
    ST_TB_RD,
    ST_TB_EV,
    ST_LEN,
    ST_SYM_RD,
    ST_SYM_WAIT
  } state_e;

  // One input item.
  typedef struct packed {
    action_e          action;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] value;
    logic             overflow;
    logic             last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic start;      // compute taken: capture lengths, clear strings
    logic row_start;  // read the first-string symbol of the current row
    logic cell_issue; // read operands of the current cell
    logic tb_issue;   // read direction and symbol of the traceback cell
    logic tb_step;    // apply the traceback direction
    logic load_len;   // load the length result into the output register
    logic sym_issue;  // read the next picked symbol
    logic load_sym;   // load a symbol result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // one of the live strings is empty
    logic col_last;   // current column is the last one
    logic row_last;   // current row is the last one
    logic tb_done;    // traceback reached an edge of the table
    logic out_free;   // output register can take a new item
    logic sym_none;   // the subsequence is empty
    logic sym_last;   // the symbol pointer is at slot zero, the last symbol
  } sts_t;

endpackage

>>> hdl/lcs_ctrl.sv
module lcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lcs_pkg::action_e  in_action_i,
  output logic              in_stall_o,
  input  lcs_pkg::sts_t     sts_i,
  output lcs_pkg::cmd_t     cmd_o
);
  import lcs_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (in_action_i == ACT_COMPUTE)) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.empty ? ST_LEN : ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row_start = 1'b1;
        state_d         = ST_CELL;
      end
      ST_CELL: begin
        cmd_o.cell_issue = 1'b1;
        if (sts_i.col_last) begin
          state_d = sts_i.row_last ? ST_FLUSH : ST_ROW;
        end
      end
      ST_FLUSH: begin
        state_d = ST_TB_RD;
      end
      ST_TB_RD: begin
        if (sts_i.tb_done) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.tb_issue = 1'b1;
          state_d        = ST_TB_EV;
        end
      end
      ST_TB_EV: begin
        cmd_o.tb_step = 1'b1;
        state_d       = ST_TB_RD;
      end
      ST_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.load_len = 1'b1;
          state_d        = sts_i.sym_none ? ST_IDLE : ST_SYM_RD;
        end
      end
      ST_SYM_RD: begin
        cmd_o.sym_issue = 1'b1;
        state_d         = ST_SYM_WAIT;
      end
      ST_SYM_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_sym = 1'b1;
          state_d        = sts_i.sym_last ? ST_IDLE : ST_SYM_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/lcs_dp.sv
module lcs_dp #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcs_pkg::in_item_t  in_item_i,
  input  lcs_pkg::cmd_t      cmd_i,
  output lcs_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lcs_pkg::out_item_t out_item_o
);
  import lcs_pkg::*;

  localparam int unsigned IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned CELLS  = MAX_LEN * MAX_LEN;
  localparam int unsigned DIR_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [DIR_AW-1:0] ROW_STEP = DIR_AW'(MAX_LEN);
  localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0]  LEN_ONE  = LEN_W'(1);

  // Storage.
  logic [SYM_W-1:0] first_mem  [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [SYM_W-1:0] pick_mem   [MAX_LEN];
  logic [LEN_W-1:0] score_mem  [MAX_LEN];
  dir_e             dir_mem    [CELLS];

  // Registers.
  logic [LEN_W-1:0]  first_len_q, second_len_q;
  logic              dropped_q, ovf_q;
  logic [LEN_W-1:0]  n1_q, n2_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic [DIR_AW-1:0] row_base_q;
  logic              ev_q, ev_first_q;
  logic [IDX_W-1:0]  ev_col_q;
  logic [DIR_AW-1:0] ev_addr_q;
  logic [LEN_W-1:0]  diag_q, left_q;
  logic [LEN_W-1:0]  i_q, j_q, cnt_q;
  logic [IDX_W-1:0]  ptr_q;
  logic [SYM_W-1:0]  t1_rd_q, t2_rd_q, pick_rd_q;
  logic [LEN_W-1:0]  sc_rd_q;
  dir_e              dir_rd_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Append decode.
  logic app_first, app_second, first_full, second_full;
  assign app_first   = cmd_i.accept && (in_item_i.action == ACT_APPEND_FIRST);
  assign app_second  = cmd_i.accept && (in_item_i.action == ACT_APPEND_SECOND);
  assign first_full  = (first_len_q == LEN_FULL);
  assign second_full = (second_len_q == LEN_FULL);

  // Traceback indexes, one below the current corner.
  logic [LEN_W-1:0] im1, jm1, cntm1;
  assign im1   = i_q - LEN_ONE;
  assign jm1   = j_q - LEN_ONE;
  assign cntm1 = cnt_q - LEN_ONE;

  logic [IDX_W-1:0] t1_addr;
  assign t1_addr = cmd_i.row_start ? row_q : im1[IDX_W-1:0];

  // Cell evaluation: match extends the diagonal, a tie goes up.
  logic [LEN_W-1:0] up_s, diag_s, left_s, score_new;
  dir_e             dir_new;
  always_comb begin
    up_s   = ev_first_q ? '0 : sc_rd_q;
    diag_s = (ev_col_q == '0) ? '0 : diag_q;
    left_s = (ev_col_q == '0) ? '0 : left_q;
    if (t1_rd_q == t2_rd_q) begin
      score_new = diag_s + LEN_ONE;
      dir_new   = DIR_DIAG;
    end else if (left_s <= up_s) begin
      score_new = up_s;
      dir_new   = DIR_UP;
    end else begin
      score_new = left_s;
      dir_new   = DIR_LEFT;
    end
  end

  // String memories.
  always_ff @(posedge clk_i) begin
    if (app_first && !first_full) begin
      first_mem[first_len_q[IDX_W-1:0]] <= in_item_i.symbol;
    end
    if (cmd_i.row_start || cmd_i.tb_issue) begin
      t1_rd_q <= first_mem[t1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (app_second && !second_full) begin
      second_mem[second_len_q[IDX_W-1:0]] <= in_item_i.symbol;
    end
    if (cmd_i.cell_issue) begin
      t2_rd_q <= second_mem[col_q];
    end
  end

  // Score row memory: holds the previous row, overwritten in place.
  always_ff @(posedge clk_i) begin
    if (ev_q) begin
      score_mem[ev_col_q] <= score_new;
    end
    if (cmd_i.cell_issue) begin
      sc_rd_q <= score_mem[col_q];
    end
  end

  // Direction table.
  always_ff @(posedge clk_i) begin
    if (ev_q) begin
      dir_mem[ev_addr_q] <= dir_new;
    end
    if (cmd_i.tb_issue) begin
      dir_rd_q <= dir_mem[row_base_q + DIR_AW'(jm1)];
    end
  end

  // Picked symbols, written backward and read forward.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tb_step && (dir_rd_q == DIR_DIAG)) begin
      pick_mem[cnt_q[IDX_W-1:0]] <= t1_rd_q;
    end
    if (cmd_i.sym_issue) begin
      pick_rd_q <= pick_mem[ptr_q];
    end
  end

  // Evaluation carries within a row.
  always_ff @(posedge clk_i) begin
    if (ev_q) begin
      diag_q <= up_s;
      left_q <= score_new;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_len) begin
      out_q.kind     <= KIND_LENGTH;
      out_q.value    <= SYM_W'(cnt_q);
      out_q.overflow <= ovf_q;
      out_q.last     <= (cnt_q == '0);
    end else if (cmd_i.load_sym) begin
      out_q.kind     <= KIND_SYMBOL;
      out_q.value    <= pick_rd_q;
      out_q.overflow <= ovf_q;
      out_q.last     <= (ptr_q == '0);
    end
  end

  // Control registers: lengths, counters, pipeline and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      dropped_q    <= 1'b0;
      ovf_q        <= 1'b0;
      n1_q         <= '0;
      n2_q         <= '0;
      row_q        <= '0;
      col_q        <= '0;
      row_base_q   <= '0;
      ev_q         <= 1'b0;
      ev_first_q   <= 1'b0;
      ev_col_q     <= '0;
      ev_addr_q    <= '0;
      i_q          <= '0;
      j_q          <= '0;
      cnt_q        <= '0;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // Appends; a full string drops the symbol and raises the flag.
      if (app_first) begin
        if (first_full) begin
          dropped_q <= 1'b1;
        end else begin
          first_len_q <= first_len_q + LEN_ONE;
        end
      end
      if (app_second) begin
        if (second_full) begin
          dropped_q <= 1'b1;
        end else begin
          second_len_q <= second_len_q + LEN_ONE;
        end
      end

      // Compute: capture the pair and clear the strings for the next one.
      if (cmd_i.start) begin
        n1_q         <= first_len_q;
        n2_q         <= second_len_q;
        i_q          <= first_len_q;
        j_q          <= second_len_q;
        ovf_q        <= dropped_q;
        dropped_q    <= 1'b0;
        first_len_q  <= '0;
        second_len_q <= '0;
        row_q        <= '0;
        col_q        <= '0;
        row_base_q   <= '0;
        cnt_q        <= '0;
      end

      // Table walk, one cell per issue.
      ev_q <= cmd_i.cell_issue;
      if (cmd_i.cell_issue) begin
        ev_col_q   <= col_q;
        ev_first_q <= (row_q == '0);
        ev_addr_q  <= row_base_q + DIR_AW'(col_q);
        if (sts_o.col_last) begin
          col_q <= '0;
          if (!sts_o.row_last) begin
            row_q      <= row_q + IDX_W'(1);
            row_base_q <= row_base_q + ROW_STEP;
          end
        end else begin
          col_q <= col_q + IDX_W'(1);
        end
      end

      // Traceback step; the row base follows the traceback row.
      if (cmd_i.tb_step) begin
        case (dir_rd_q)
          DIR_DIAG: begin
            cnt_q      <= cnt_q + LEN_ONE;
            i_q        <= im1;
            j_q        <= jm1;
            row_base_q <= row_base_q - ROW_STEP;
          end
          DIR_UP: begin
            i_q        <= im1;
            row_base_q <= row_base_q - ROW_STEP;
          end
          default: begin
            j_q <= jm1;
          end
        endcase
      end

      // Symbol pointer for forward readout.
      if (cmd_i.load_len) begin
        ptr_q <= cntm1[IDX_W-1:0];
      end else if (cmd_i.load_sym) begin
        ptr_q <= ptr_q - IDX_W'(1);
      end

      // Output register valid.
      if (cmd_i.load_len || cmd_i.load_sym) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status.
  assign sts_o.empty    = (first_len_q == '0) || (second_len_q == '0);
  assign sts_o.col_last = ((LEN_W'(col_q) + LEN_ONE) == n2_q);
  assign sts_o.row_last = ((LEN_W'(row_q) + LEN_ONE) == n1_q);
  assign sts_o.tb_done  = (i_q == '0) || (j_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.sym_none = (cnt_q == '0);
  assign sts_o.sym_last = (ptr_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> hdl/lcs_length_and_traceback.sv
// Longest common subsequence of two byte strings. Append items add one
// symbol to the first or second string (up to MAX_LEN each; extra symbols
// are dropped and reported through the overflow bit); a compute item empties
// both strings as it is taken, fills the direction table, traces it back
// from the full corner and returns the length followed by the subsequence
// symbols in forward order, with last set on the final result. The table
// fill handles one cell per cycle, with a row step before each row to fetch
// the row symbol; each traceback step (at most n1 + n2 steps for strings of
// lengths n1 and n2) reads the registered direction table and then applies
// the direction; the length and each symbol, read through the pick buffer,
// are loaded into the output register when it is free. The block takes no
// new item while a compute is in progress, but the last result may still
// wait in the output register while the next items are accepted.
module lcs_length_and_traceback #(
  parameter int unsigned MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lcs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lcs_pkg::out_item_t out_item_o
);
  import lcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  lcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, table walk, traceback and output register.
  lcs_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Only one memory read phase is active at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.row_start, cmd.cell_issue, cmd.tb_issue, cmd.sym_issue}))
    else $error("more than one read phase active");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_len || cmd.load_sym) |-> sts.out_free)
    else $error("result loaded over a pending result");

  // An accepted compute holds off further input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_item_i.action == ACT_COMPUTE)) |=> in_stall_o)
    else $error("input accepted right after a compute");

  // A compute of two non-empty strings starts the table walk on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.start && !sts.empty) |=> cmd.row_start)
    else $error("table walk did not start after compute");

endmodule
